@@ hdl/mme_pkg.sv @@
package mme_pkg;

    // Default sizing
    localparam int MAX_DIM_DEFAULT    = 8;
    localparam int DATA_WIDTH_DEFAULT = 16;

    // Fixed field widths
    localparam int ELEM_WIDTH      = 16;
    localparam int PRODUCT_WIDTH   = 35;
    localparam int CFG_DATA_WIDTH  = 4;
    localparam int CFG_INDEX_WIDTH = 2;

    // Register indexes
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_ROW_COUNT   = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_INNER_COUNT = 2'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_COL_COUNT   = 2'd2;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_LOAD_A,
        ST_LOAD_B,
        ST_MAC,
        ST_WAIT
    } state_t;

    // Tag that follows each memory read through the MAC pipeline
    typedef struct packed {
        logic valid;
        logic first;
        logic last;
        logic last_result;
    } mac_tag_t;

endpackage

@@ hdl/mme_in_if.sv @@
interface mme_in_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [mme_pkg::ELEM_WIDTH-1:0] element_value;

    modport source (output valid, output element_value, input ready);
    modport sink   (input valid, input element_value, output ready);
endinterface

@@ hdl/mme_out_if.sv @@
interface mme_out_if;
    logic                                    valid;
    logic                                    ready;
    logic signed [mme_pkg::PRODUCT_WIDTH-1:0] product_value;
    logic                                    last_flag;

    modport source (output valid, output product_value, output last_flag, input ready);
    modport sink   (input valid, input product_value, input last_flag, output ready);
endinterface

@@ hdl/mme_ram.sv @@
module mme_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                                       clk,
    input  logic                                       wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                           wr_data,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                           rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Single write port, registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

@@ hdl/mme_ctrl.sv @@
module mme_ctrl #(
    parameter int MAX_DIM = mme_pkg::MAX_DIM_DEFAULT
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      cfg_we,
    input  logic [mme_pkg::CFG_INDEX_WIDTH-1:0]       cfg_index,
    input  logic [mme_pkg::CFG_DATA_WIDTH-1:0]        cfg_data,
    input  logic                                      in_valid,
    output logic                                      in_ready,
    output logic                                      left_we,
    output logic                                      right_we,
    output logic [(MAX_DIM * MAX_DIM > 1 ? $clog2(MAX_DIM * MAX_DIM) : 1)-1:0] wr_addr,
    output logic [(MAX_DIM * MAX_DIM > 1 ? $clog2(MAX_DIM * MAX_DIM) : 1)-1:0] rd_a_addr,
    output logic [(MAX_DIM * MAX_DIM > 1 ? $clog2(MAX_DIM * MAX_DIM) : 1)-1:0] rd_b_addr,
    output mme_pkg::mac_tag_t                         issue,
    input  logic                                      mac_idle
);

    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int AW    = DEPTH > 1 ? $clog2(DEPTH) : 1;
    localparam int DIM_W = $clog2(MAX_DIM + 1);
    localparam int IDX_W = MAX_DIM > 1 ? $clog2(MAX_DIM) : 1;
    localparam int PW    = 2 * DIM_W;
    localparam int CW    = mme_pkg::CFG_DATA_WIDTH;

    // Dimension register 0 acts as 1, above MAX_DIM acts as MAX_DIM
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [CW-1:0] v);
        logic [DIM_W-1:0] r;
        if (v == '0)
        begin
            r = DIM_W'(1);
        end
        else if (v > CW'(MAX_DIM))
        begin
            r = DIM_W'(MAX_DIM);
        end
        else
        begin
            r = DIM_W'(v);
        end
        return r;
    endfunction

    mme_pkg::state_t state_reg, state_next;

    logic [CW-1:0]    row_reg, row_next;
    logic [CW-1:0]    inner_reg, inner_next;
    logic [CW-1:0]    col_reg, col_next;
    logic             cfg_hit;

    logic [AW-1:0]    load_pos_reg, load_pos_next;
    logic [IDX_W-1:0] t_reg, t_next;
    logic [IDX_W-1:0] j_reg, j_next;
    logic [IDX_W-1:0] i_reg, i_next;
    logic [AW-1:0]    a_row_reg, a_row_next;
    logic [AW-1:0]    a_addr_reg, a_addr_next;
    logic [AW-1:0]    b_addr_reg, b_addr_next;
    logic             done_reg, done_next;

    logic [DIM_W-1:0] m, k, n;
    logic [PW-1:0]    mk, kn, pos_inc;
    logic             in_fire, load_last;
    logic             t_last, j_last, i_last;

    // Effective dimensions and load bounds
    assign m       = clamp_dim(row_reg);
    assign k       = clamp_dim(inner_reg);
    assign n       = clamp_dim(col_reg);
    assign mk      = PW'(m) * PW'(k);
    assign kn      = PW'(k) * PW'(n);
    assign pos_inc = PW'(load_pos_reg) + PW'(1);
    assign in_fire = in_valid && in_ready;
    assign load_last = (state_reg == mme_pkg::ST_LOAD_B) ? (pos_inc >= kn) : (pos_inc >= mk);

    assign t_last = (t_reg == IDX_W'(k - DIM_W'(1)));
    assign j_last = (j_reg == IDX_W'(n - DIM_W'(1)));
    assign i_last = (i_reg == IDX_W'(m - DIM_W'(1)));

    // Register decode; any listed register restarts loading
    always_comb
    begin
        row_next   = row_reg;
        inner_next = inner_reg;
        col_next   = col_reg;
        cfg_hit    = 1'b0;
        if (cfg_we)
        begin
            unique case (cfg_index)
                mme_pkg::CFG_ROW_COUNT:
                begin
                    row_next = cfg_data;
                    cfg_hit  = 1'b1;
                end
                mme_pkg::CFG_INNER_COUNT:
                begin
                    inner_next = cfg_data;
                    cfg_hit    = 1'b1;
                end
                mme_pkg::CFG_COL_COUNT:
                begin
                    col_next = cfg_data;
                    cfg_hit  = 1'b1;
                end
                default:
                begin
                    cfg_hit = 1'b0;
                end
            endcase
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            mme_pkg::ST_LOAD_A:
            begin
                if (in_fire && load_last)
                begin
                    state_next = mme_pkg::ST_LOAD_B;
                end
            end
            mme_pkg::ST_LOAD_B:
            begin
                if (in_fire && load_last)
                begin
                    state_next = mme_pkg::ST_MAC;
                end
            end
            mme_pkg::ST_MAC:
            begin
                if (t_last)
                begin
                    state_next = mme_pkg::ST_WAIT;
                end
            end
            mme_pkg::ST_WAIT:
            begin
                if (mac_idle)
                begin
                    state_next = done_reg ? mme_pkg::ST_LOAD_A : mme_pkg::ST_MAC;
                end
            end
            default:
            begin
                state_next = mme_pkg::ST_LOAD_A;
            end
        endcase
        if (cfg_hit)
        begin
            state_next = mme_pkg::ST_LOAD_A;
        end
    end

    // Outputs
    always_comb
    begin
        in_ready          = 1'b0;
        left_we           = 1'b0;
        right_we          = 1'b0;
        issue.valid       = 1'b0;
        issue.first       = (t_reg == '0);
        issue.last        = t_last;
        issue.last_result = i_last && j_last;
        unique case (state_reg)
            mme_pkg::ST_LOAD_A:
            begin
                in_ready = 1'b1;
                left_we  = in_valid;
            end
            mme_pkg::ST_LOAD_B:
            begin
                in_ready = 1'b1;
                right_we = in_valid;
            end
            mme_pkg::ST_MAC:
            begin
                issue.valid = 1'b1;
            end
            mme_pkg::ST_WAIT:
            begin
                issue.valid = 1'b0;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    assign wr_addr   = load_pos_reg;
    assign rd_a_addr = a_addr_reg;
    assign rd_b_addr = b_addr_reg;

    // Load position and MAC index counters
    always_comb
    begin
        load_pos_next = load_pos_reg;
        t_next        = t_reg;
        j_next        = j_reg;
        i_next        = i_reg;
        a_row_next    = a_row_reg;
        a_addr_next   = a_addr_reg;
        b_addr_next   = b_addr_reg;
        done_next     = done_reg;
        unique case (state_reg)
            mme_pkg::ST_LOAD_A:
            begin
                if (in_fire)
                begin
                    load_pos_next = load_last ? '0 : AW'(pos_inc);
                end
            end
            mme_pkg::ST_LOAD_B:
            begin
                if (in_fire)
                begin
                    if (load_last)
                    begin
                        load_pos_next = '0;
                        t_next        = '0;
                        j_next        = '0;
                        i_next        = '0;
                        a_row_next    = '0;
                        a_addr_next   = '0;
                        b_addr_next   = '0;
                        done_next     = 1'b0;
                    end
                    else
                    begin
                        load_pos_next = AW'(pos_inc);
                    end
                end
            end
            mme_pkg::ST_MAC:
            begin
                if (t_last)
                begin
                    t_next    = '0;
                    done_next = i_last && j_last;
                    if (j_last)
                    begin
                        j_next      = '0;
                        i_next      = i_reg + IDX_W'(1);
                        a_row_next  = a_row_reg + AW'(k);
                        a_addr_next = a_row_reg + AW'(k);
                        b_addr_next = '0;
                    end
                    else
                    begin
                        j_next      = j_reg + IDX_W'(1);
                        a_addr_next = a_row_reg;
                        b_addr_next = AW'(j_reg) + AW'(1);
                    end
                end
                else
                begin
                    t_next      = t_reg + IDX_W'(1);
                    a_addr_next = a_addr_reg + AW'(1);
                    b_addr_next = b_addr_reg + AW'(n);
                end
            end
            mme_pkg::ST_WAIT:
            begin
                done_next = done_reg;
            end
            default:
            begin
                done_next = done_reg;
            end
        endcase
        if (cfg_hit)
        begin
            load_pos_next = '0;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= mme_pkg::ST_LOAD_A;
            row_reg      <= CW'(8);
            inner_reg    <= CW'(8);
            col_reg      <= CW'(8);
            load_pos_reg <= '0;
            t_reg        <= '0;
            j_reg        <= '0;
            i_reg        <= '0;
            a_row_reg    <= '0;
            a_addr_reg   <= '0;
            b_addr_reg   <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            row_reg      <= row_next;
            inner_reg    <= inner_next;
            col_reg      <= col_next;
            load_pos_reg <= load_pos_next;
            t_reg        <= t_next;
            j_reg        <= j_next;
            i_reg        <= i_next;
            a_row_reg    <= a_row_next;
            a_addr_reg   <= a_addr_next;
            b_addr_reg   <= b_addr_next;
            done_reg     <= done_next;
        end
    end

    // A new dot product only starts into an empty MAC pipeline
    a_first_issue_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (issue.valid && issue.first) |-> mac_idle)
        else $error("dot product started while MAC pipeline busy");

    // Load position stays inside the matrix being loaded
    a_load_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == mme_pkg::ST_LOAD_A) |-> (pos_inc <= mk)) and
        ((state_reg == mme_pkg::ST_LOAD_B) |-> (pos_inc <= kn)))
        else $error("load position beyond matrix size");

    // Read addresses stay inside the loaded matrices
    a_read_bound: assert property (@(posedge clk) disable iff (!rst_n)
        issue.valid |-> ((PW'(a_addr_reg) < mk) && (PW'(b_addr_reg) < kn)))
        else $error("operand read outside loaded matrix");

endmodule

@@ hdl/mme_mac.sv @@
module mme_mac #(
    parameter int DATA_WIDTH = mme_pkg::DATA_WIDTH_DEFAULT
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  mme_pkg::mac_tag_t     issue,
    input  logic [DATA_WIDTH-1:0] a_data,
    input  logic [DATA_WIDTH-1:0] b_data,
    output logic                  mac_idle,
    mme_out_if.source             result
);

    localparam int PRW = 2 * DATA_WIDTH;
    localparam int ACW = mme_pkg::PRODUCT_WIDTH;

    mme_pkg::mac_tag_t s1_tag_reg;
    mme_pkg::mac_tag_t s2_tag_reg;

    logic signed [PRW-1:0] prod_reg;
    logic signed [ACW-1:0] prod_ext;
    logic signed [ACW-1:0] acc_reg, acc_next;
    logic                  acc_valid_reg, acc_valid_next;
    logic                  acc_last_reg;
    logic                  out_valid_reg, out_valid_next;
    logic signed [ACW-1:0] out_value_reg;
    logic                  out_last_reg;
    logic                  out_free, hand_off;

    assign prod_ext = {{(ACW - PRW){prod_reg[PRW-1]}}, prod_reg};
    assign out_free = !out_valid_reg || result.ready;
    assign hand_off = acc_valid_reg && out_free;
    assign mac_idle = !s1_tag_reg.valid && !s2_tag_reg.valid && !acc_valid_reg;

    // Accumulate; first term of a dot product restarts the sum
    always_comb
    begin
        acc_next = acc_reg;
        if (s2_tag_reg.valid)
        begin
            acc_next = s2_tag_reg.first ? prod_ext : acc_reg + prod_ext;
        end
    end

    // Finished sum waits in the accumulator until the output register frees up
    always_comb
    begin
        acc_valid_next = acc_valid_reg;
        out_valid_next = out_valid_reg;
        if (hand_off)
        begin
            acc_valid_next = 1'b0;
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (s2_tag_reg.valid && s2_tag_reg.last)
        begin
            acc_valid_next = 1'b1;
        end
    end

    // Pipeline control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_tag_reg    <= '0;
            s2_tag_reg    <= '0;
            acc_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_tag_reg    <= issue;
            s2_tag_reg    <= s1_tag_reg;
            acc_valid_reg <= acc_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath: multiply on read data, accumulate, output register
    always_ff @(posedge clk)
    begin
        prod_reg <= $signed(a_data) * $signed(b_data);
        acc_reg  <= acc_next;
        if (s2_tag_reg.valid && s2_tag_reg.last)
        begin
            acc_last_reg <= s2_tag_reg.last_result;
        end
        if (hand_off)
        begin
            out_value_reg <= acc_reg;
            out_last_reg  <= acc_last_reg;
        end
    end

    assign result.valid         = out_valid_reg;
    assign result.product_value = out_value_reg;
    assign result.last_flag     = out_last_reg;

    // Last term of a dot product always lands a result
    a_last_term: assert property (@(posedge clk) disable iff (!rst_n)
        (s2_tag_reg.valid && s2_tag_reg.last) |=> acc_valid_reg)
        else $error("completed dot product not held");

    // Pending result is never overwritten by new terms
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        s2_tag_reg.valid |-> !acc_valid_reg)
        else $error("accumulator overwritten while result pending");

    // Stalled output keeps the pending result
    a_hold_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (acc_valid_reg && out_valid_reg && !result.ready) |=> acc_valid_reg)
        else $error("pending result lost under stall");

endmodule

@@ hdl/matrix_multiply_engine_core.sv @@
// Dense matrix multiply C = A x B on signed fixed-point elements.
// Channel element: A (row_count x inner_count) then B (inner_count x col_count),
// both row-major, one element per transfer; low DATA_WIDTH bits, sign-extended.
// Channel result: C row-major, 35-bit exact sums, last_flag on the final element.
// Config port: cfg_we/cfg_index/cfg_data write row_count, inner_count, col_count
// (0 acts as 1, above MAX_DIM acts as MAX_DIM); any such write restarts loading.
// Loading takes one element per cycle while ready is high. After the last B
// element, each C element is formed by inner_count reads of the two operand
// memories, then the read/multiply/accumulate pipeline drains before the next starts.
// The shared multiply-accumulate and the one read port of each memory set the
// pace of a matrix pass.
// Output is registered; a finished sum waits in the accumulator while the
// receiver stalls, so loading of the next A starts as soon as the last sum is
// handed to the output register. Reset: loading A, dimensions 8, no results
// pending; operand memory contents are not cleared (every read entry is loaded first).
module matrix_multiply_engine_core #(
    parameter int MAX_DIM    = mme_pkg::MAX_DIM_DEFAULT,
    parameter int DATA_WIDTH = mme_pkg::DATA_WIDTH_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [mme_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [mme_pkg::CFG_DATA_WIDTH-1:0]  cfg_data,
    mme_in_if.sink                              element,
    mme_out_if.source                           result
);

    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int AW    = DEPTH > 1 ? $clog2(DEPTH) : 1;

    logic                  in_ready;
    logic                  left_we, right_we;
    logic [AW-1:0]         wr_addr, rd_a_addr, rd_b_addr;
    logic [DATA_WIDTH-1:0] a_data, b_data;
    logic                  mac_idle;
    mme_pkg::mac_tag_t     issue;

    assign element.ready = in_ready;

    // Sequencer: loading, dimensions, MAC addressing
    mme_ctrl #(
        .MAX_DIM (MAX_DIM)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (element.valid),
        .in_ready  (in_ready),
        .left_we   (left_we),
        .right_we  (right_we),
        .wr_addr   (wr_addr),
        .rd_a_addr (rd_a_addr),
        .rd_b_addr (rd_b_addr),
        .issue     (issue),
        .mac_idle  (mac_idle)
    );

    // Operand memories
    mme_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_left_ram (
        .clk     (clk),
        .wr_en   (left_we),
        .wr_addr (wr_addr),
        .wr_data (element.element_value[DATA_WIDTH-1:0]),
        .rd_addr (rd_a_addr),
        .rd_data (a_data)
    );

    mme_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_right_ram (
        .clk     (clk),
        .wr_en   (right_we),
        .wr_addr (wr_addr),
        .wr_data (element.element_value[DATA_WIDTH-1:0]),
        .rd_addr (rd_b_addr),
        .rd_data (b_data)
    );

    // Multiply-accumulate and output register
    mme_mac #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_mac (
        .clk      (clk),
        .rst_n    (rst_n),
        .issue    (issue),
        .a_data   (a_data),
        .b_data   (b_data),
        .mac_idle (mac_idle),
        .result   (result)
    );

endmodule

@@ verif/mme_product_checker.sv @@
// Watches the config port and both channels, keeps its own copy of the
// multiply state and queues the C elements it expects.
module mme_product_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [mme_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [mme_pkg::CFG_DATA_WIDTH-1:0]  cfg_data,
    mme_in_if                                   element_mon,
    mme_out_if                                  result_mon,
    output int                                  fail_count,
    output int                                  pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import mme_pkg::*;

    localparam int STORE_DEPTH = MAX_DIM_DEFAULT * MAX_DIM_DEFAULT;

    typedef struct packed {
        logic signed [PRODUCT_WIDTH-1:0] value;
        logic                            last;
    } product_t;

    product_t                      product_queue[$];
    logic [CFG_DATA_WIDTH-1:0]     dim_reg [0:2];
    logic signed [ELEM_WIDTH-1:0]  left_mem [0:STORE_DEPTH-1];
    logic signed [ELEM_WIDTH-1:0]  right_mem [0:STORE_DEPTH-1];
    int                            load_pos;
    state_t                        phase;

    // 0 acts as 1, anything above the array size acts as the array size
    function automatic int clamp_dim(input logic [CFG_DATA_WIDTH-1:0] raw);
        if (raw == 0)
            return 1;
        if (raw > MAX_DIM_DEFAULT)
            return MAX_DIM_DEFAULT;
        return int'(raw);
    endfunction

    // Store one element of A or B; the last B element yields all of C
    task automatic take_element(input logic signed [ELEM_WIDTH-1:0] v);
        int       m;
        int       k;
        int       n;
        longint   acc;
        product_t p;
        m = clamp_dim(dim_reg[CFG_ROW_COUNT]);
        k = clamp_dim(dim_reg[CFG_INNER_COUNT]);
        n = clamp_dim(dim_reg[CFG_COL_COUNT]);
        if (phase != ST_LOAD_B)
        begin
            left_mem[load_pos] = v;
            if (load_pos + 1 >= m * k)
            begin
                phase    = ST_LOAD_B;
                load_pos = 0;
            end
            else
                load_pos++;
        end
        else
        begin
            right_mem[load_pos] = v;
            if (load_pos + 1 < k * n)
                load_pos++;
            else
            begin
                for (int i = 0; i < m; i++)
                begin
                    for (int j = 0; j < n; j++)
                    begin
                        acc = 0;
                        for (int t = 0; t < k; t++)
                            acc += longint'(left_mem[i * k + t]) * longint'(right_mem[t * n + j]);
                        p.value = acc[PRODUCT_WIDTH-1:0];
                        p.last  = (i == m - 1) && (j == n - 1);
                        product_queue.push_back(p);
                    end
                end
                load_pos = 0;
                phase    = ST_LOAD_A;
            end
        end
    endtask

    initial
    begin
        fail_count = 0;
        pending    = 0;
    end

    always @(posedge clk or negedge rst_n)
    begin : watch
        product_t want;
        if (!rst_n)
        begin
            for (int r = 0; r < 3; r++)
                dim_reg[r] = 4'd8;
            load_pos = 0;
            phase    = ST_LOAD_A;
            product_queue.delete();
        end
        else
        begin
            // result transfer: compare with the oldest expected element
            if (result_mon.valid && result_mon.ready)
            begin
                if (product_queue.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: unexpected result: expected none, actual value %0d last %0b",
                             $time, result_mon.product_value, result_mon.last_flag);
                end
                else
                begin
                    want = product_queue.pop_front();
                    if (result_mon.product_value !== want.value ||
                        result_mon.last_flag !== want.last)
                    begin
                        fail_count++;
                        $display("%0t: result: expected value %0d last %0b, actual value %0d last %0b",
                                 $time, want.value, want.last,
                                 result_mon.product_value, result_mon.last_flag);
                    end
                end
            end
            // register write restarts loading; the unused index does nothing
            if (cfg_we && (cfg_index == CFG_ROW_COUNT || cfg_index == CFG_INNER_COUNT ||
                           cfg_index == CFG_COL_COUNT))
            begin
                dim_reg[cfg_index] = cfg_data;
                load_pos           = 0;
                phase              = ST_LOAD_A;
            end
            if (element_mon.valid && element_mon.ready)
                take_element(element_mon.element_value);
        end
        pending = product_queue.size();
    end

endmodule

@@ verif/testbench.sv @@
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import mme_pkg::*;

    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_UNUSED = 2'd3;
    localparam int RANDOM_ITEMS  = 380;
    localparam int SETTLE_CYCLES = 16;

    logic                       clk;
    logic                       rst_n;
    logic                       cfg_we;
    logic [CFG_INDEX_WIDTH-1:0] cfg_index;
    logic [CFG_DATA_WIDTH-1:0]  cfg_data;
    int                         fail_count;
    int                         pending;
    bit                         calm = 1'b0;
    int                         stall_left = 0;
    int                         random_items = 0;
    logic [CFG_DATA_WIDTH-1:0]  dim_shadow [0:2];

    mme_in_if  element_ch();
    mme_out_if result_ch();

    matrix_multiply_engine_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .element   (element_ch),
        .result    (result_ch)
    );

    mme_product_checker product_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .element_mon (element_ch),
        .result_mon  (result_ch),
        .fail_count  (fail_count),
        .pending     (pending)
    );

    initial clk = 1'b0;
    always #1 clk = ~clk;

    // Receiver stalls in random bursts
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left--;
            result_ch.ready <= 1'b0;
        end
        else if (!calm && $urandom_range(0, 7) == 0)
        begin
            stall_left = $urandom_range(0, 9);
            result_ch.ready <= 1'b0;
        end
        else
            result_ch.ready <= 1'b1;
    end

    function automatic int eff_dim(input logic [CFG_DATA_WIDTH-1:0] raw);
        if (raw == 0)
            return 1;
        if (raw > MAX_DIM_DEFAULT)
            return MAX_DIM_DEFAULT;
        return int'(raw);
    endfunction

    // Elements in one full A plus B at the current sizes
    function automatic int pass_items();
        int k;
        k = eff_dim(dim_shadow[CFG_INNER_COUNT]);
        return k * (eff_dim(dim_shadow[CFG_ROW_COUNT]) + eff_dim(dim_shadow[CFG_COL_COUNT]));
    endfunction

    // Mostly small sizes, sometimes full size or out-of-range codes
    function automatic logic [CFG_DATA_WIDTH-1:0] pick_dim();
        int                        r;
        logic [CFG_DATA_WIDTH-1:0] d;
        r = $urandom_range(0, 15);
        if (r < 9)
            d = CFG_DATA_WIDTH'($urandom_range(1, 3));
        else if (r < 11)
            d = CFG_DATA_WIDTH'($urandom_range(4, 7));
        else if (r < 13)
            d = 4'd8;
        else if (r == 13)
            d = 4'd0;
        else
            d = CFG_DATA_WIDTH'($urandom_range(9, 15));
        return d;
    endfunction

    function automatic logic [ELEM_WIDTH-1:0] pick_value();
        logic [ELEM_WIDTH-1:0] v;
        case ($urandom_range(0, 11))
            0:       v = 16'h8000;
            1:       v = 16'h7fff;
            2:       v = 16'h0000;
            3:       v = 16'hffff;
            default: v = ELEM_WIDTH'($urandom());
        endcase
        return v;
    endfunction

    // One element transfer, with an occasional gap in front of it
    task automatic push_element(input logic [ELEM_WIDTH-1:0] v);
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            element_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge clk);
        end
        element_ch.valid         <= 1'b1;
        element_ch.element_value <= v;
        @(posedge clk);
        while (!element_ch.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_elements(input bit pinned, input int count);
        for (int e = 0; e < count; e++)
            push_element(pinned ? 16'h8000 : pick_value());
    endtask

    // Hold the sender until every expected result is out, then let the block go quiet
    task automatic settle();
        element_ch.valid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_WIDTH-1:0] idx,
                             input logic [CFG_DATA_WIDTH-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
        if (idx != CFG_UNUSED)
            dim_shadow[idx] = data;
    endtask

    initial
    begin
        #1000000;
        $display("matrix_multiply_engine_core: mismatch");
        $finish;
    end

    initial
    begin : stimulus
        int choice;
        int count;
        rst_n                    = 1'b0;
        cfg_we                   = 1'b0;
        cfg_index                = '0;
        cfg_data                 = '0;
        element_ch.valid         = 1'b0;
        element_ch.element_value = '0;
        result_ch.ready          = 1'b0;
        for (int r = 0; r < 3; r++)
            dim_shadow[r] = 4'd8;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // 1x1x1 with the most negative operands
        write_reg(CFG_ROW_COUNT, 4'd1);
        write_reg(CFG_INNER_COUNT, 4'd1);
        write_reg(CFG_COL_COUNT, 4'd1);
        push_element(16'h8000);
        push_element(16'h8000);

        // zero sizes act as 1
        settle();
        write_reg(CFG_ROW_COUNT, 4'd0);
        write_reg(CFG_INNER_COUNT, 4'd0);
        write_reg(CFG_COL_COUNT, 4'd0);
        push_element(16'h7fff);
        push_element(16'h8000);

        // oversize codes act as 8: outer product giving the full 64 results
        settle();
        write_reg(CFG_ROW_COUNT, 4'd15);
        write_reg(CFG_INNER_COUNT, 4'd1);
        write_reg(CFG_COL_COUNT, 4'd15);
        for (int e = 0; e < 8; e++)
            push_element(e[0] ? 16'h7fff : 16'h8000);
        push_element(16'h8000);
        push_element(16'h7fff);
        push_element(16'h0000);
        push_element(16'hffff);
        push_element(16'h0001);
        push_element(16'h8000);
        push_element(16'h7fff);
        push_element(16'h1234);

        // write while A is half loaded discards it; the unused index changes nothing
        settle();
        write_reg(CFG_ROW_COUNT, 4'd1);
        write_reg(CFG_INNER_COUNT, 4'd2);
        write_reg(CFG_COL_COUNT, 4'd1);
        push_element(pick_value());
        settle();
        write_reg(CFG_COL_COUNT, 4'd1);
        push_element(pick_value());
        push_element(pick_value());
        settle();
        write_reg(CFG_UNUSED, 4'd5);
        push_element(pick_value());
        push_element(pick_value());

        // random passes, some broken off by a register write
        while (random_items < RANDOM_ITEMS)
        begin
            if (random_items > RANDOM_ITEMS - 60)
                calm = 1'b1;
            choice = $urandom_range(0, 9);
            if (choice < 3)
            begin
                settle();
                write_reg(CFG_ROW_COUNT, pick_dim());
                write_reg(CFG_INNER_COUNT, pick_dim());
                write_reg(CFG_COL_COUNT, pick_dim());
                if ($urandom_range(0, 3) == 0)
                    write_reg(CFG_UNUSED, CFG_DATA_WIDTH'($urandom_range(0, 15)));
            end
            else if (choice == 3)
            begin
                count = $urandom_range(1, pass_items() - 1);
                send_elements(1'b0, count);
                random_items += count;
                settle();
                write_reg(CFG_INDEX_WIDTH'($urandom_range(CFG_ROW_COUNT, CFG_COL_COUNT)),
                          pick_dim());
            end
            else if (choice == 4)
                settle();
            count = pass_items();
            send_elements($urandom_range(0, 7) == 0, count);
            random_items += count;
        end

        // drain
        element_ch.valid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        repeat (40) @(negedge clk);
        if (fail_count == 0)
            $display("matrix_multiply_engine_core: match");
        else
            $display("matrix_multiply_engine_core: mismatch");
        $finish;
    end

endmodule

@@ filelist.f @@
hdl/mme_pkg.sv
hdl/mme_in_if.sv
hdl/mme_out_if.sv
hdl/mme_ram.sv
hdl/mme_ctrl.sv
hdl/mme_mac.sv
hdl/matrix_multiply_engine_core.sv
verif/mme_product_checker.sv
verif/testbench.sv
